// ===== src/dhd_pkg.sv =====
`default_nettype none

package dhd_pkg;

    // one tensor element, signed q11.12
    typedef logic signed [23:0] value_t;

    // row columns ahead of the class scores
    localparam int unsigned LEAD_VALUES  = 5;
    localparam int unsigned COL_CENTER_X = 0;
    localparam int unsigned COL_CENTER_Y = 1;
    localparam int unsigned COL_WIDTH    = 2;
    localparam int unsigned COL_HEIGHT   = 3;
    localparam int unsigned COL_OBJ      = 4;

    // class limits
    localparam int unsigned MAX_CLASSES = 128;
    localparam int unsigned CLASS_LIMIT = (MAX_CLASSES < 128) ? MAX_CLASSES : 128;

    // fixed point
    localparam int unsigned CONF_FRAC = 12;
    localparam int unsigned CONF_ONE  = 4096;

    // magnitude of |(2c +/- s) * frame| >> 13 stays below 2**MAG_BITS
    localparam int unsigned MAG_BITS = 25;

    // register indexes
    localparam logic [1:0] REG_CONF_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_CLASS_COUNT    = 2'd1;
    localparam logic [1:0] REG_FRAME_WIDTH    = 2'd2;
    localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd3;

    // snapshot of a finished row
    typedef struct packed {
        value_t     cx;
        value_t     cy;
        value_t     bw;
        value_t     bh;
        value_t     obj;
        value_t     best;
        logic [6:0] cls;
        logic       last;
    } row_t;

    // power-of-two factor of a model dimension
    function automatic int unsigned trailing_zeros(input int unsigned x);
        int unsigned n;
        logic        done;
        n    = 0;
        done = 1'b0;
        for (int i = 0; i < 13; i++) begin
            if (!done) begin
                if (x[i]) begin
                    done = 1'b1;
                end else begin
                    n++;
                end
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== src/detection_head_decode_core.sv =====
`default_nettype none

// Detection head decoder with class argmax. The input stream carries the detector output tensor
// one signed q11.12 element per word (s_tdata[23:0]), s_tlast high on the tensor's final word.
// Each row is cx, cy, w, h, objectness and then class_count class scores; the argmax starts at
// class 0 with score 0 and moves only on a strictly greater score. One result word leaves per
// completed row: m_tuser is the kept flag, m_tlast marks the tensor's last row, and m_tdata holds
// class_idx, confidence (objectness * best score, unsigned q1.12, saturated at 4096) and the four corners
// scaled from the model size to the frame size, truncated toward zero and saturated to 16 bits.
// A dropped row gives zeros in every data field. A tensor end in the middle of a row drops the
// partial row with no result. Throughput is one word per clock while s_tready is high; a row's
// result is offered on m_tvalid through a five-stage result pipeline (row capture at the
// accepting edge, products, magnitude shift, reciprocal multiply for the odd part of the model
// size, saturation). s_tready drops only when all five stages hold results and m_tready
// is low.
// Registers (apb, byte address 4*i): 0 conf_threshold, 1 class_count, 2 frame_width,
// 3 frame_height; write them only while no row is in flight.

module detection_head_decode_core #(
    parameter int unsigned MODEL_WIDTH  = 640,
    parameter int unsigned MODEL_HEIGHT = 640
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [23:0] value
    input  wire logic        s_tlast,   // tensor_end

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // [6:0] class_idx, [19:7] confidence, [35:20] box_left,
                                        // [51:36] box_top, [67:52] box_right,
                                        // [83:68] box_bottom, [87:84] zero
    output logic             m_tuser,   // kept
    output logic             m_tlast,   // last_row

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import dhd_pkg::*;

    // divide by 2*model*4096: shift out the power of two, reciprocal for the odd part
    localparam int unsigned KX  = trailing_zeros(MODEL_WIDTH);
    localparam int unsigned OX  = MODEL_WIDTH >> KX;
    localparam int unsigned LX  = $clog2(OX);
    localparam int unsigned SHX = CONF_FRAC + 1 + KX;
    localparam int unsigned WX  = MAG_BITS - KX;
    localparam int unsigned SX  = WX + LX;
    localparam int unsigned MBX = WX + 2;
    localparam int unsigned PX  = WX + MBX;
    localparam logic [63:0] MX  = ((64'd1 << SX) + 64'(OX) - 64'd1) / 64'(OX);

    localparam int unsigned KY  = trailing_zeros(MODEL_HEIGHT);
    localparam int unsigned OY  = MODEL_HEIGHT >> KY;
    localparam int unsigned LY  = $clog2(OY);
    localparam int unsigned SHY = CONF_FRAC + 1 + KY;
    localparam int unsigned WY  = MAG_BITS - KY;
    localparam int unsigned SY  = WY + LY;
    localparam int unsigned MBY = WY + 2;
    localparam int unsigned PY  = WY + MBY;
    localparam logic [63:0] MY  = ((64'd1 << SY) + 64'(OY) - 64'd1) / 64'(OY);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [12:0] conf_threshold_reg;
    logic [7:0]  class_count_reg;
    logic [12:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conf_threshold_reg <= 13'd1024;
            class_count_reg    <= 8'd80;
            frame_width_reg    <= 13'd640;
            frame_height_reg   <= 13'd480;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_CONF_THRESHOLD: conf_threshold_reg <= pwdata[12:0];
                REG_CLASS_COUNT:    class_count_reg    <= pwdata[7:0];
                REG_FRAME_WIDTH:    frame_width_reg    <= pwdata[12:0];
                REG_FRAME_HEIGHT:   frame_height_reg   <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CONF_THRESHOLD: prdata = {19'd0, conf_threshold_reg};
            REG_CLASS_COUNT:    prdata = {24'd0, class_count_reg};
            REG_FRAME_WIDTH:    prdata = {19'd0, frame_width_reg};
            REG_FRAME_HEIGHT:   prdata = {19'd0, frame_height_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline handshake: each stage takes a result when empty or moving on
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, m_valid_reg;
    logic s2_ready, s3_ready, s4_ready, out_ready;

    assign out_ready = !m_valid_reg  | m_tready;
    assign s4_ready  = !s4_valid_reg | out_ready;
    assign s3_ready  = !s3_valid_reg | s4_ready;
    assign s2_ready  = !s2_valid_reg | s3_ready;
    assign s_tready  = !s1_valid_reg | s2_ready;
    assign m_tvalid  = m_valid_reg;

    // ------------------------------------------------------------------
    // row accumulation, one word per clock while s_tready is high
    // ------------------------------------------------------------------
    logic [7:0] column_index_reg, column_index_next;
    value_t     center_x_reg, center_x_next;
    value_t     center_y_reg, center_y_next;
    value_t     box_width_reg, box_width_next;
    value_t     box_height_reg, box_height_next;
    value_t     objectness_reg, objectness_next;
    value_t     best_score_reg, best_score_next;
    logic [6:0] best_class_reg, best_class_next;

    logic [7:0] classes_used;
    logic [7:0] last_col;
    value_t     in_value;
    logic       in_accept;
    logic       score_up;
    logic       row_done;
    logic       row_emit;
    row_t       s1_row_reg, s1_row_next;

    always_comb begin
        if (class_count_reg == 8'd0) begin
            classes_used = 8'd1;
        end else if (class_count_reg > 8'(CLASS_LIMIT)) begin
            classes_used = 8'(CLASS_LIMIT);
        end else begin
            classes_used = class_count_reg;
        end
        last_col  = 8'(LEAD_VALUES - 1) + classes_used;
        in_value  = s_tdata[23:0];
        in_accept = s_tvalid & s_tready;
        score_up  = (column_index_reg >= 8'(LEAD_VALUES)) && (in_value > best_score_reg);
        row_done  = column_index_reg >= last_col;
        row_emit  = in_accept & row_done;

        column_index_next = column_index_reg;
        center_x_next     = center_x_reg;
        center_y_next     = center_y_reg;
        box_width_next    = box_width_reg;
        box_height_next   = box_height_reg;
        objectness_next   = objectness_reg;
        best_score_next   = best_score_reg;
        best_class_next   = best_class_reg;

        if (in_accept) begin
            if (column_index_reg == 8'(COL_CENTER_X)) begin
                center_x_next = in_value;
            end else if (column_index_reg == 8'(COL_CENTER_Y)) begin
                center_y_next = in_value;
            end else if (column_index_reg == 8'(COL_WIDTH)) begin
                box_width_next = in_value;
            end else if (column_index_reg == 8'(COL_HEIGHT)) begin
                box_height_next = in_value;
            end else if (column_index_reg == 8'(COL_OBJ)) begin
                objectness_next = in_value;
            end
            if (score_up) begin
                best_score_next = in_value;
                best_class_next = 7'(column_index_reg - 8'(LEAD_VALUES));
            end
            // row finished or tensor cut short: start a fresh row
            if (row_done || s_tlast) begin
                column_index_next = 8'd0;
                best_score_next   = '0;
                best_class_next   = 7'd0;
            end else begin
                column_index_next = column_index_reg + 8'd1;
            end
        end

        // final row values, with the last score folded in
        s1_row_next.cx   = center_x_reg;
        s1_row_next.cy   = center_y_reg;
        s1_row_next.bw   = box_width_reg;
        s1_row_next.bh   = box_height_reg;
        s1_row_next.obj  = objectness_reg;
        s1_row_next.best = score_up ? in_value : best_score_reg;
        s1_row_next.cls  = score_up ? 7'(column_index_reg - 8'(LEAD_VALUES)) : best_class_reg;
        s1_row_next.last = s_tlast;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_index_reg <= 8'd0;
            best_score_reg   <= '0;
            best_class_reg   <= 7'd0;
        end else begin
            column_index_reg <= column_index_next;
            best_score_reg   <= best_score_next;
            best_class_reg   <= best_class_next;
        end
    end

    // box values are always rewritten before a row completes
    always_ff @(posedge aclk) begin
        center_x_reg   <= center_x_next;
        center_y_reg   <= center_y_next;
        box_width_reg  <= box_width_next;
        box_height_reg <= box_height_next;
        objectness_reg <= objectness_next;
    end

    // stage 1: row capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= row_emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (row_emit) begin
            s1_row_reg <= s1_row_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: confidence product and scaled corner products
    // ------------------------------------------------------------------
    logic signed [47:0] s2_prod_reg, s2_prod_next;
    value_t             s2_obj_reg;
    logic [6:0]         s2_cls_reg;
    logic               s2_last_reg;
    logic signed [39:0] s2_px_reg [2];     // left, right
    logic signed [39:0] s2_py_reg [2];     // top, bottom
    logic signed [39:0] s2_px_next [2];
    logic signed [39:0] s2_py_next [2];
    logic signed [25:0] cx2, cy2, bw_e, bh_e;
    logic signed [13:0] fw_s, fh_s;

    always_comb begin
        s2_prod_next  = s1_row_reg.obj * s1_row_reg.best;
        cx2           = $signed({s1_row_reg.cx[23], s1_row_reg.cx, 1'b0});
        cy2           = $signed({s1_row_reg.cy[23], s1_row_reg.cy, 1'b0});
        bw_e          = $signed({{2{s1_row_reg.bw[23]}}, s1_row_reg.bw});
        bh_e          = $signed({{2{s1_row_reg.bh[23]}}, s1_row_reg.bh});
        fw_s          = $signed({1'b0, frame_width_reg});
        fh_s          = $signed({1'b0, frame_height_reg});
        s2_px_next[0] = (cx2 - bw_e) * fw_s;
        s2_px_next[1] = (cx2 + bw_e) * fw_s;
        s2_py_next[0] = (cy2 - bh_e) * fh_s;
        s2_py_next[1] = (cy2 + bh_e) * fh_s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            s2_prod_reg  <= s2_prod_next;
            s2_obj_reg   <= s1_row_reg.obj;
            s2_cls_reg   <= s1_row_reg.cls;
            s2_last_reg  <= s1_row_reg.last;
            s2_px_reg[0] <= s2_px_next[0];
            s2_px_reg[1] <= s2_px_next[1];
            s2_py_reg[0] <= s2_py_next[0];
            s2_py_reg[1] <= s2_py_next[1];
        end
    end

    // ------------------------------------------------------------------
    // stage 3: keep decision, confidence, corner magnitudes
    // ------------------------------------------------------------------
    logic            s3_kept_reg, s3_kept_next;
    logic [12:0]     s3_conf_reg, s3_conf_next;
    logic [6:0]      s3_cls_reg;
    logic            s3_last_reg;
    logic [WX-1:0]   s3_nx_reg [2];
    logic [WY-1:0]   s3_ny_reg [2];
    logic [WX-1:0]   s3_nx_next [2];
    logic [WY-1:0]   s3_ny_next [2];
    logic            s3_negx_reg [2];
    logic            s3_negy_reg [2];
    logic [39:0]     ax [2];
    logic [39:0]     ay [2];

    always_comb begin
        s3_kept_next = (s2_obj_reg >= $signed({11'd0, conf_threshold_reg}))
                    && (s2_prod_reg >= $signed({23'd0, conf_threshold_reg, 12'd0}));
        // product is never negative on a kept row
        if ((s2_prod_reg[46:25] != 22'd0) || (s2_prod_reg[24:12] > 13'(CONF_ONE))) begin
            s3_conf_next = 13'(CONF_ONE);
        end else begin
            s3_conf_next = s2_prod_reg[24:12];
        end
        for (int i = 0; i < 2; i++) begin
            ax[i]         = s2_px_reg[i][39] ? 40'(-s2_px_reg[i]) : 40'(s2_px_reg[i]);
            ay[i]         = s2_py_reg[i][39] ? 40'(-s2_py_reg[i]) : 40'(s2_py_reg[i]);
            s3_nx_next[i] = WX'(ax[i] >> SHX);
            s3_ny_next[i] = WY'(ay[i] >> SHY);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_ready && s2_valid_reg) begin
            s3_kept_reg <= s3_kept_next;
            s3_conf_reg <= s3_conf_next;
            s3_cls_reg  <= s2_cls_reg;
            s3_last_reg <= s2_last_reg;
            for (int i = 0; i < 2; i++) begin
                s3_nx_reg[i]   <= s3_nx_next[i];
                s3_ny_reg[i]   <= s3_ny_next[i];
                s3_negx_reg[i] <= s2_px_reg[i][39];
                s3_negy_reg[i] <= s2_py_reg[i][39];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 4: exact division by the odd part of the model size
    // ------------------------------------------------------------------
    logic            s4_kept_reg;
    logic [12:0]     s4_conf_reg;
    logic [6:0]      s4_cls_reg;
    logic            s4_last_reg;
    logic [WX-1:0]   s4_qx_reg [2];
    logic [WY-1:0]   s4_qy_reg [2];
    logic            s4_negx_reg [2];
    logic            s4_negy_reg [2];
    logic [PX-1:0]   fx [2];
    logic [PY-1:0]   fy [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            fx[i] = PX'(s3_nx_reg[i]) * PX'(MX);
            fy[i] = PY'(s3_ny_reg[i]) * PY'(MY);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (s4_ready) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_ready && s3_valid_reg) begin
            s4_kept_reg <= s3_kept_reg;
            s4_conf_reg <= s3_conf_reg;
            s4_cls_reg  <= s3_cls_reg;
            s4_last_reg <= s3_last_reg;
            for (int i = 0; i < 2; i++) begin
                s4_qx_reg[i]   <= WX'(fx[i] >> SX);
                s4_qy_reg[i]   <= WY'(fy[i] >> SY);
                s4_negx_reg[i] <= s3_negx_reg[i];
                s4_negy_reg[i] <= s3_negy_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 5: sign, saturation, output word
    // ------------------------------------------------------------------
    function automatic logic [15:0] sat_corner(input logic neg, input logic [MAG_BITS-1:0] mag);
        logic [MAG_BITS-1:0] neg_mag;
        logic [15:0]         r;
        neg_mag = -mag;
        if (!neg) begin
            r = (mag > MAG_BITS'(32767)) ? 16'h7FFF : mag[15:0];
        end else begin
            r = (mag > MAG_BITS'(32768)) ? 16'h8000 : neg_mag[15:0];
        end
        return r;
    endfunction

    logic [87:0] m_data_reg, m_data_next;
    logic        m_kept_reg;
    logic        m_last_reg;

    always_comb begin
        if (s4_kept_reg) begin
            m_data_next = {4'd0,
                           sat_corner(s4_negy_reg[1], MAG_BITS'(s4_qy_reg[1])),
                           sat_corner(s4_negx_reg[1], MAG_BITS'(s4_qx_reg[1])),
                           sat_corner(s4_negy_reg[0], MAG_BITS'(s4_qy_reg[0])),
                           sat_corner(s4_negx_reg[0], MAG_BITS'(s4_qx_reg[0])),
                           s4_conf_reg,
                           s4_cls_reg};
        end else begin
            m_data_next = 88'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && s4_valid_reg) begin
            m_data_reg <= m_data_next;
            m_kept_reg <= s4_kept_reg;
            m_last_reg <= s4_last_reg;
        end
    end

    assign m_tdata = m_data_reg;
    assign m_tuser = m_kept_reg;
    assign m_tlast = m_last_reg;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import dhd_pkg::*;

    // clock, model geometry and run limits
    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 11;
    localparam int MODEL_WIDTH  = 640;
    localparam int MODEL_HEIGHT = 640;
    localparam int DRAIN_CYCLES = 12;     // result pipeline is five deep, plus margin
    localparam int STALL_LIMIT  = 2000;   // cycles with no transfer on any port
    localparam int PHASE_WORDS  = 155;    // stimulus words per random phase
    localparam int PRINT_LIMIT  = 40;

    // one tensor element as it waits in the send queue
    typedef struct packed {
        value_t value;
        logic   tensor_end;
    } element_t;

    // one decoded row as it leaves the block
    typedef struct packed {
        logic              kept;
        logic [6:0]        class_idx;
        logic [12:0]       confidence;
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic signed [15:0] box_right;
        logic signed [15:0] box_bottom;
        logic              last_row;
    } detection_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // words still to be sent and rows still to come back
    element_t   tensor_words[$];
    element_t   next_word;
    detection_t expected_detections[$];

    // percentage of cycles in which each side holds off
    int unsigned send_idle = 22;
    int unsigned recv_idle = 49;

    int mismatch_count = 0;
    int result_count   = 0;
    int stall_cycles   = 0;

    // register copies, starting at their reset values
    logic [12:0] cfg_threshold    = 13'd1024;
    logic [7:0]  cfg_class_count  = 8'd80;
    logic [12:0] cfg_frame_width  = 13'd640;
    logic [12:0] cfg_frame_height = 13'd480;

    // row being assembled by the decoder copy
    logic [7:0] row_column     = '0;
    value_t     row_cx         = '0;
    value_t     row_cy         = '0;
    value_t     row_w          = '0;
    value_t     row_h          = '0;
    value_t     row_obj        = '0;
    value_t     row_best_score = '0;
    logic [6:0] row_best_class = '0;

    detection_head_decode_core #(
        .MODEL_WIDTH  (MODEL_WIDTH),
        .MODEL_HEIGHT (MODEL_HEIGHT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [23:0] value
        .s_tlast  (s_tlast),   // tensor_end
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [6:0] class_idx, [19:7] confidence, [35:20] box_left,
                               // [51:36] box_top, [67:52] box_right, [83:68] box_bottom
        .m_tuser  (m_tuser),   // kept
        .m_tlast  (m_tlast),   // last_row
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // one line per mismatch, printing capped, counting never
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("result %0d %s: got %0h, expected %0h", result_count, what, got, want);
        end
        mismatch_count++;
    endtask

    // class scores per row after clamping to the supported range
    function automatic int unsigned active_class_count();
        int unsigned n;
        n = cfg_class_count;
        if (n < 1) n = 1;
        if (n > CLASS_LIMIT) n = CLASS_LIMIT;
        return n;
    endfunction

    // one box edge in frame pixels: exact quotient, toward zero, then 16-bit saturation
    function automatic logic [15:0] scaled_corner(input longint centre, input longint size,
                                                  input bit plus, input logic [12:0] frame,
                                                  input longint model);
        longint twice;
        longint q;
        twice = plus ? (2 * centre + size) : (2 * centre - size);
        q = (twice * longint'(frame)) / (2 * model * longint'(CONF_ONE));
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    task automatic clear_row();
        row_column     = '0;
        row_cx         = '0;
        row_cy         = '0;
        row_w          = '0;
        row_h          = '0;
        row_obj        = '0;
        row_best_score = '0;
        row_best_class = '0;
    endtask

    // feed one accepted element to the decoder copy, queue a detection at row end
    task automatic decode_element(input value_t v, input logic tend);
        int unsigned last_col;
        longint      prod;
        longint      conf;
        detection_t  d;
        last_col = LEAD_VALUES + active_class_count() - 1;
        if (row_column == COL_CENTER_X) row_cx = v;
        else if (row_column == COL_CENTER_Y) row_cy = v;
        else if (row_column == COL_WIDTH) row_w = v;
        else if (row_column == COL_HEIGHT) row_h = v;
        else if (row_column == COL_OBJ) row_obj = v;
        else if (v > row_best_score) begin
            // argmax moves only on a strictly greater score
            row_best_score = v;
            row_best_class = 7'(row_column - LEAD_VALUES);
        end
        if (row_column < last_col) begin
            // a tensor end inside a row throws the partial row away
            if (tend) clear_row();
            else row_column = row_column + 8'd1;
            return;
        end
        prod = longint'(row_obj) * longint'(row_best_score);
        d = '0;
        if (longint'(row_obj) >= longint'(cfg_threshold) &&
            prod >= longint'(cfg_threshold) * longint'(CONF_ONE)) begin
            conf = prod / longint'(CONF_ONE);
            d.kept       = 1'b1;
            d.class_idx  = row_best_class;
            d.confidence = (conf > longint'(CONF_ONE)) ? 13'(CONF_ONE) : conf[12:0];
            d.box_left   = scaled_corner(row_cx, row_w, 1'b0, cfg_frame_width, MODEL_WIDTH);
            d.box_top    = scaled_corner(row_cy, row_h, 1'b0, cfg_frame_height, MODEL_HEIGHT);
            d.box_right  = scaled_corner(row_cx, row_w, 1'b1, cfg_frame_width, MODEL_WIDTH);
            d.box_bottom = scaled_corner(row_cy, row_h, 1'b1, cfg_frame_height, MODEL_HEIGHT);
        end
        d.last_row = tend;
        expected_detections.insert(expected_detections.size(), d);
        clear_row();
    endtask

    // apb write, then read back; the copy takes the value at the write edge
    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        logic [31:0] mask;
        logic [31:0] readback;
        mask = (idx == REG_CLASS_COUNT) ? 32'h0000_00FF : 32'h0000_1FFF;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_CONF_THRESHOLD: cfg_threshold    = data[12:0];
            REG_CLASS_COUNT:    cfg_class_count  = data[7:0];
            REG_FRAME_WIDTH:    cfg_frame_width  = data[12:0];
            REG_FRAME_HEIGHT:   cfg_frame_height = data[12:0];
            default: ;
        endcase
        // straight into the read setup, psel stays high
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== (data & mask)) report_mismatch("register readback", readback, data & mask);
    endtask

    task automatic queue_word(input int v, input bit tend);
        element_t w;
        w.value      = value_t'(v);
        w.tensor_end = tend;
        tensor_words.insert(tensor_words.size(), w);
    endtask

    // wait until every word is taken and every row is back, then let the pipe settle
    task automatic wait_pipeline_empty();
        while (tensor_words.size() != 0 || s_tvalid || expected_detections.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // element content by column: box values, objectness near one, scores with ties
    function automatic value_t element_value(input int col, input bit noise,
                                             input value_t best_so_far);
        if (noise || $urandom_range(15) == 0) return value_t'($urandom);
        if (col < COL_OBJ) begin
            if ($urandom_range(3) == 0) return value_t'($urandom);
            return value_t'(int'($urandom_range(2700000)) - 60000);
        end
        if (col == COL_OBJ) return value_t'(int'($urandom_range(4600)) - 300);
        if ($urandom_range(4) == 0) return best_so_far;
        return value_t'(int'($urandom_range(5000)) - 800);
    endfunction

    // mostly whole rows with random content, some noise rows and cut rows
    task automatic queue_random_rows(input int budget);
        int       row_len;
        int       cut;
        int       queued;
        bit       noise;
        bit       tend;
        value_t   best_so_far;
        value_t   v;
        element_t w;
        queued  = 0;
        row_len = LEAD_VALUES + active_class_count();
        while (queued < budget) begin
            noise = ($urandom_range(9) == 0);
            cut   = ($urandom_range(9) == 0) ? $urandom_range(row_len - 1, 1) : row_len;
            best_so_far = '0;
            for (int k = 0; k < cut; k++) begin
                v = element_value(k, noise, best_so_far);
                if (k >= LEAD_VALUES && v > best_so_far) best_so_far = v;
                tend = (k == cut - 1) &&
                       (cut < row_len || queued + cut >= budget || $urandom_range(5) == 0);
                w.value      = v;
                w.tensor_end = tend;
                tensor_words.insert(tensor_words.size(), w);
            end
            queued += cut;
        end
    endtask

    // compare one result word with the oldest waiting detection
    task automatic check_detection();
        detection_t got;
        detection_t want;
        got.kept       = m_tuser;
        got.class_idx  = m_tdata[6:0];
        got.confidence = m_tdata[19:7];
        got.box_left   = m_tdata[35:20];
        got.box_top    = m_tdata[51:36];
        got.box_right  = m_tdata[67:52];
        got.box_bottom = m_tdata[83:68];
        got.last_row   = m_tlast;
        if (expected_detections.size() == 0) begin
            report_mismatch("word with no row pending", m_tdata[31:0], '0);
            result_count++;
            return;
        end
        want = expected_detections.pop_front();
        if (got.kept !== want.kept) report_mismatch("kept", got.kept, want.kept);
        if (got.class_idx !== want.class_idx)
            report_mismatch("class_idx", got.class_idx, want.class_idx);
        if (got.confidence !== want.confidence)
            report_mismatch("confidence", got.confidence, want.confidence);
        if (got.box_left !== want.box_left)
            report_mismatch("box_left", got.box_left, want.box_left);
        if (got.box_top !== want.box_top)
            report_mismatch("box_top", got.box_top, want.box_top);
        if (got.box_right !== want.box_right)
            report_mismatch("box_right", got.box_right, want.box_right);
        if (got.box_bottom !== want.box_bottom)
            report_mismatch("box_bottom", got.box_bottom, want.box_bottom);
        if (got.last_row !== want.last_row)
            report_mismatch("last_row", got.last_row, want.last_row);
        if (m_tdata[87:84] !== 4'b0000) report_mismatch("padding", m_tdata[87:84], '0);
        result_count++;
    endtask

    // input driver: a word taken at this edge goes to the decoder copy,
    // a new word is offered whenever the slot is free and the sender is not idling
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_element(value_t'(s_tdata), s_tlast);
            end
            if (!s_tvalid || s_tready) begin
                if (tensor_words.size() != 0 && $urandom_range(99) >= send_idle) begin
                    next_word = tensor_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_word.value;
                    s_tlast  <= next_word.tensor_end;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_detection();
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog: any transfer on any port restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("detection_head_decode_core: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        int unsigned setting [4];
        int          mode;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows, two classes, other registers at reset values
        write_register(REG_CLASS_COUNT, 32'd2);
        // ordinary kept row, small negative center, class 1 wins
        queue_word(-100, 1'b0);
        queue_word(240 * 4096, 1'b0);
        queue_word(150 * 4096, 1'b0);
        queue_word(80 * 4096, 1'b0);
        queue_word(3500, 1'b0);
        queue_word(3000, 1'b0);
        queue_word(4000, 1'b0);
        // extreme values, equal top scores keep class 0, confidence saturates
        queue_word(8388607, 1'b0);
        queue_word(-8388608, 1'b0);
        queue_word(8388607, 1'b0);
        queue_word(-8388608, 1'b0);
        queue_word(8388607, 1'b0);
        queue_word(8388607, 1'b0);
        queue_word(8388607, 1'b0);
        // tensor end in the middle of a row, no result
        queue_word(1000, 1'b0);
        queue_word(2000, 1'b1);
        // low objectness, negative scores: dropped row on the tensor's last row
        queue_word(10 * 4096, 1'b0);
        queue_word(10 * 4096, 1'b0);
        queue_word(5 * 4096, 1'b0);
        queue_word(5 * 4096, 1'b0);
        queue_word(500, 1'b0);
        queue_word(-5, 1'b0);
        queue_word(-8388608, 1'b1);
        wait_pipeline_empty();

        // random phases, each under its own register setting
        for (int p = 1; p <= 10; p++) begin
            // receiver idles more first, then sender, then neither idles
            mode = (p * 3) / 11;
            send_idle = (mode == 0) ? 22 : (mode == 1) ? 49 : 0;
            recv_idle = (mode == 0) ? 49 : (mode == 1) ? 22 : 0;
            case (p)
                1: setting = '{1024, 4, 640, 480};
                2: setting = '{0, 1, 1, 1};           // zero threshold, smallest frame
                3: setting = '{4096, 3, 8191, 8191};  // corners saturate
                4: setting = '{8191, 2, 4096, 640};   // threshold above one
                5: setting = '{200, 0, 0, 0};         // count clamps up, zero frame
                6: setting = '{2048, 255, 1920, 1080};// count clamps down
                7: setting = '{600, 80, 4096, 4096};
                8: setting = '{3000, 7, 1280, 720};
                default: begin
                    setting[REG_CONF_THRESHOLD] = $urandom_range(4096);
                    setting[REG_CLASS_COUNT]    = $urandom_range(12, 1);
                    setting[REG_FRAME_WIDTH]    = $urandom_range(4096, 1);
                    setting[REG_FRAME_HEIGHT]   = $urandom_range(4096, 1);
                end
            endcase
            for (int r = 0; r < 4; r++) write_register(2'(r), setting[r]);
            queue_random_rows(PHASE_WORDS);
            wait_pipeline_empty();
        end

        if (mismatch_count == 0) begin
            $display("detection_head_decode_core: match");
        end else begin
            $display("detection_head_decode_core: mismatch");
        end
        $finish;
    end

endmodule
